>>> rtl/wgas_pkg.sv
// ---------------------------------------------------------------------------
// wgas_pkg: shared types and codes for the weighted graph adjacency store
// Request opcodes, status codes and the fixed widths of the request and
// result fields.
// ---------------------------------------------------------------------------
package wgas_pkg;

	// fixed field widths on the ports
	localparam int OP_BITS        = 3;
	localparam int ID_IN_BITS     = 16;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int STATUS_BITS    = 3;

	// request opcodes
	typedef enum logic [OP_BITS-1:0] {
		OP_ADD_VERTEX = 3'd0,
		OP_DEL_VERTEX = 3'd1,
		OP_ADD_EDGE   = 3'd2,
		OP_UPD_EDGE   = 3'd3,
		OP_DEL_EDGE   = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE    = 3'd0,
		ST_EXISTS  = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_FULL    = 3'd3,
		ST_NO_EDGE = 3'd4
	} status_t;

endpackage

>>> rtl/weighted_graph_adjacency_store.sv
// A request is registered, then committed in the execute state (which waits
// while an untaken result is held and matches ids against all slots); no
// request is taken there. An edge's mirrored weight write uses the single
// weight memory port while the next request is taken.
// Reset clears slot valid bits and the edge matrix at once; no clearing pass.
// Vertex ids and weights are held only until overwritten (no reset).
// ---------------------------------------------------------------------------
// weighted_graph_adjacency_store
// Undirected weighted graph kept as vertex slots, a symmetric edge-present
// matrix in flops and a slot-pair indexed weight memory.
// ---------------------------------------------------------------------------
module weighted_graph_adjacency_store
	import wgas_pkg::*;
#(
	parameter int MAX_VERTICES = 16,
	parameter int ID_BITS      = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [OP_BITS-1:0]               operation,
	input  logic [ID_IN_BITS-1:0]            first_id,
	input  logic [ID_IN_BITS-1:0]            second_id,
	input  logic signed [WEIGHT_IN_BITS-1:0] edge_weight_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [STATUS_BITS-1:0]           status
);

	localparam int SLOT_BITS = $clog2(MAX_VERTICES);
	localparam int DEPTH     = MAX_VERTICES * MAX_VERTICES;
	localparam int ADDR_BITS = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_MIRROR = 3'b100
	} state_t;

	state_t state_q, state_d;

	// request registers
	op_t                    op_q;
	logic [ID_BITS-1:0]     ida_q, idb_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [ID_BITS-1:0]     ida_in, idb_in;
	logic [WEIGHT_BITS-1:0] w_in;

	// slot and edge state
	logic [MAX_VERTICES-1:0] slot_valid_q;
	logic [ID_BITS-1:0]      slot_id_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] edge_q    [MAX_VERTICES];
	logic [WEIGHT_BITS-1:0]  weight_mem [DEPTH];

	// output register
	logic          out_valid_q;
	status_t       status_q;

	// execute decode
	logic [MAX_VERTICES-1:0] hit_a, hit_b;
	logic                    any_a, any_b, any_free;
	logic [SLOT_BITS-1:0]    a_idx, b_idx, free_idx, tgt_idx;
	logic                    has_edge;
	status_t                 st;
	logic                    do_add_v, do_del_v, do_set_e, do_clr_e, do_wr_w;
	logic                    in_xfer, commit;
	logic [ADDR_BITS-1:0]    addr_ab, addr_ba, mirror_addr_q, mem_addr;
	logic                    mem_we;

	// field width adaptation
	if (ID_BITS <= ID_IN_BITS) begin : g_id_cut
		assign ida_in = first_id[ID_BITS-1:0];
		assign idb_in = second_id[ID_BITS-1:0];
	end else begin : g_id_ext
		assign ida_in = {{(ID_BITS-ID_IN_BITS){1'b0}}, first_id};
		assign idb_in = {{(ID_BITS-ID_IN_BITS){1'b0}}, second_id};
	end

	if (WEIGHT_BITS <= WEIGHT_IN_BITS) begin : g_w_cut
		assign w_in = edge_weight_in[WEIGHT_BITS-1:0];
	end else begin : g_w_ext
		assign w_in = {{(WEIGHT_BITS-WEIGHT_IN_BITS){edge_weight_in[WEIGHT_IN_BITS-1]}},
			edge_weight_in};
	end

	// handshake
	assign in_ready  = (state_q == S_IDLE) || (state_q == S_MIRROR);
	assign in_xfer   = in_valid && in_ready;
	assign commit    = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign status    = status_q;

	// parallel id match and free slot search, lowest slot wins
	always_comb begin
		any_a    = 1'b0;
		any_b    = 1'b0;
		any_free = 1'b0;
		a_idx    = '0;
		b_idx    = '0;
		free_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			hit_a[i] = slot_valid_q[i] && (slot_id_q[i] == ida_q);
			hit_b[i] = slot_valid_q[i] && (slot_id_q[i] == idb_q);
		end
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (hit_a[i]) begin
				any_a = 1'b1;
				a_idx = SLOT_BITS'(i);
			end
			if (hit_b[i]) begin
				any_b = 1'b1;
				b_idx = SLOT_BITS'(i);
			end
			if (!slot_valid_q[i]) begin
				any_free = 1'b1;
				free_idx = SLOT_BITS'(i);
			end
		end
	end

	assign has_edge = edge_q[a_idx][b_idx];
	assign addr_ab  = ADDR_BITS'(a_idx) * ADDR_BITS'(MAX_VERTICES) + ADDR_BITS'(b_idx);
	assign addr_ba  = ADDR_BITS'(b_idx) * ADDR_BITS'(MAX_VERTICES) + ADDR_BITS'(a_idx);
	assign tgt_idx  = (op_q == OP_ADD_VERTEX) ? free_idx : a_idx;

	// request decode and status
	always_comb begin
		st       = ST_DONE;
		do_add_v = 1'b0;
		do_del_v = 1'b0;
		do_set_e = 1'b0;
		do_clr_e = 1'b0;
		do_wr_w  = 1'b0;
		case (op_q)
			OP_ADD_VERTEX: begin
				if (any_a) st = ST_EXISTS;
				else if (!any_free) st = ST_FULL;
				else do_add_v = 1'b1;
			end
			OP_DEL_VERTEX: begin
				if (!any_a) st = ST_UNKNOWN;
				else do_del_v = 1'b1;
			end
			OP_ADD_EDGE: begin
				if (!(any_a && any_b)) st = ST_UNKNOWN;
				else if (has_edge) st = ST_EXISTS;
				else begin
					do_set_e = 1'b1;
					do_wr_w  = 1'b1;
				end
			end
			OP_UPD_EDGE: begin
				if (!(any_a && any_b)) st = ST_UNKNOWN;
				else if (!has_edge) st = ST_NO_EDGE;
				else do_wr_w = 1'b1;
			end
			OP_DEL_EDGE: begin
				if (!(any_a && any_b)) st = ST_UNKNOWN;
				else if (!has_edge) st = ST_NO_EDGE;
				else do_clr_e = 1'b1;
			end
			default: st = ST_DONE;
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_xfer) state_d = S_EXEC;
			S_EXEC: if (commit) state_d = do_wr_w ? S_MIRROR : S_IDLE;
			S_MIRROR: state_d = in_xfer ? S_EXEC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= op_t'(operation);
			ida_q <= ida_in;
			idb_q <= idb_in;
			w_q   <= w_in;
		end
		if (commit) begin
			status_q      <= st;
			mirror_addr_q <= addr_ba;
		end
	end

	// slot table and edge matrix updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) edge_q[i] <= '0;
		end else if (commit) begin
			if (do_add_v) slot_valid_q[tgt_idx] <= 1'b1;
			if (do_del_v) slot_valid_q[tgt_idx] <= 1'b0;
			if (do_add_v || do_del_v) begin
				for (int j = 0; j < MAX_VERTICES; j++) begin
					edge_q[tgt_idx][j] <= 1'b0;
					edge_q[j][tgt_idx] <= 1'b0;
				end
			end
			if (do_set_e) begin
				edge_q[a_idx][b_idx] <= 1'b1;
				edge_q[b_idx][a_idx] <= 1'b1;
			end
			if (do_clr_e) begin
				edge_q[a_idx][b_idx] <= 1'b0;
				edge_q[b_idx][a_idx] <= 1'b0;
			end
		end
	end

	// vertex ids, written into the claimed slot
	always_ff @(posedge clk) begin
		if (commit && do_add_v) slot_id_q[tgt_idx] <= ida_q;
	end

	// weight memory: forward entry at execute, mirrored entry the next cycle
	assign mem_we   = (commit && do_wr_w) || (state_q == S_MIRROR);
	assign mem_addr = (state_q == S_MIRROR) ? mirror_addr_q : addr_ab;

	always_ff @(posedge clk) begin
		if (mem_we) weight_mem[mem_addr] <= w_q;
	end

endmodule
